// ===== design/pwms_pkg.sv =====
// ----------------------------------------------------------------------------
// pwms_pkg
// shared types and constants of the position window mean and sd block
// ----------------------------------------------------------------------------
`default_nettype none

package pwms_pkg;

    localparam int POS_W = 32;
    localparam int VAL_W = 16;
    localparam int SD_W  = 16;
    localparam int CNT_W = 6;

    typedef enum logic [1:0] {
        OP_DIV  = 2'b01,
        OP_SQRT = 2'b10
    } arith_op_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [SD_W-1:0]  sd;
        logic [VAL_W-1:0] mean;
        logic [POS_W-1:0] pos;
    } res_t;

endpackage

`default_nettype wire

// ===== design/pwms_ram.sv =====
// ----------------------------------------------------------------------------
// pwms_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module pwms_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== design/pwms_arith.sv =====
// ----------------------------------------------------------------------------
// pwms_arith
// shared iterative unit: restoring divide (one bit a cycle) and
// integer square root (one root bit a cycle)
// ----------------------------------------------------------------------------
`default_nettype none

module pwms_arith #(
    parameter int WW = 44
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire pwms_pkg::arith_op_t op,
    input  wire logic [WW-1:0]       a,
    input  wire logic [WW-1:0]       b,
    output logic                     done,
    output logic [WW-1:0]            result
);

    localparam int SQ = (WW + 1) / 2;
    localparam int XW = 2 * SQ;
    localparam int KW = $clog2(WW + 1);

    pwms_pkg::arith_op_t op_reg, op_next;
    logic [XW-1:0] x_reg, x_next;
    logic [WW-1:0] b_reg, b_next;
    logic [WW-1:0] r_reg, r_next;
    logic [WW+1:0] rem_reg, rem_next;
    logic [KW-1:0] k_reg, k_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;

    logic [WW+1:0] rem_sh;
    logic [WW+1:0] d;
    logic          ge;

    always_comb
    begin
        if (op_reg == pwms_pkg::OP_DIV)
        begin
            rem_sh = {rem_reg[WW:0], x_reg[XW-1]};
            d      = {2'b00, b_reg};
        end
        else
        begin
            rem_sh = {rem_reg[WW-1:0], x_reg[XW-1 -: 2]};
            d      = {r_reg, 2'b01};
        end
        ge = (rem_sh >= d);
    end

    always_comb
    begin
        op_next   = op_reg;
        x_next    = x_reg;
        b_next    = b_reg;
        r_next    = r_reg;
        rem_next  = rem_reg;
        k_next    = k_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            op_next   = op;
            b_next    = b;
            r_next    = '0;
            rem_next  = '0;
            busy_next = 1'b1;
            if (op == pwms_pkg::OP_DIV)
            begin
                x_next = XW'(a) << (XW - WW);
                k_next = KW'(WW);
            end
            else
            begin
                x_next = XW'(a);
                k_next = KW'(SQ);
            end
        end
        else if (busy_reg)
        begin
            rem_next = ge ? (rem_sh - d) : rem_sh;
            r_next   = {r_reg[WW-2:0], ge};
            x_next   = (op_reg == pwms_pkg::OP_DIV) ? (x_reg << 1) : (x_reg << 2);
            k_next   = k_reg - KW'(1);
            if (k_reg == KW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg   <= pwms_pkg::OP_DIV;
            k_reg    <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            op_reg   <= op_next;
            k_reg    <= k_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        b_reg   <= b_next;
        r_reg   <= r_next;
        rem_reg <= rem_next;
    end

    assign done   = done_reg;
    assign result = r_reg;

endmodule

`default_nettype wire

// ===== design/pwms_stats.sv =====
// ----------------------------------------------------------------------------
// pwms_stats
// result engine: scans the ring for one center point, then derives mean
// and sample standard deviation on the shared divide / root unit
// ----------------------------------------------------------------------------
`default_nettype none

module pwms_stats #(
    parameter int DEPTH = 32
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [$clog2(DEPTH+1)-1:0]   center,
    input  wire logic [$clog2(DEPTH)-1:0]     oldest,
    input  wire logic [$clog2(DEPTH+1)-1:0]   count,
    input  wire logic [31:0]                  half_width,
    output logic      [$clog2(DEPTH)-1:0]     raddr,
    input  wire logic [47:0]                  rdata,
    output logic                              busy,
    output logic                              done,
    output pwms_pkg::res_t                    res
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = 16 + CW;
    localparam int QW = 31 + CW;
    localparam int WW = 32 + 2 * CW;

    typedef enum logic [10:0] {
        E_IDLE  = 11'b00000000001,
        E_CRD   = 11'b00000000010,
        E_CAP   = 11'b00000000100,
        E_SCAN  = 11'b00000001000,
        E_MEAN  = 11'b00000010000,
        E_MEANW = 11'b00000100000,
        E_PROD  = 11'b00001000000,
        E_NUM   = 11'b00010000000,
        E_SDW   = 11'b00100000000,
        E_SQW   = 11'b01000000000,
        E_DONE  = 11'b10000000000
    } est_t;

    function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
                                           input logic [CW-1:0] off);
        logic [CW:0] s;
        s = (CW+1)'(base) + (CW+1)'(off);
        if (s >= (CW+1)'(DEPTH))
        begin
            s = s - (CW+1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    est_t state_reg, state_next;

    logic [31:0]          xc_reg, xc_next;
    logic [CW-1:0]        ti_reg, ti_next;
    logic                 iss_reg, iss_next;
    logic                 p2_reg, p2_next;
    logic                 in_reg, in_next;
    logic signed [15:0]   val_reg, val_next;
    logic [30:0]          sq_reg, sq_next;
    logic signed [SW-1:0] s_reg, s_next;
    logic [QW-1:0]        q_reg, q_next;
    logic [CW-1:0]        n_reg, n_next;
    logic [15:0]          mean_reg, mean_next;
    logic [15:0]          sd_reg, sd_next;
    logic [CW+QW-1:0]     t1_reg, t1_next;
    logic [2*SW-1:0]      t2_reg, t2_next;
    logic [2*CW-1:0]      den_reg, den_next;

    logic                 a_start;
    pwms_pkg::arith_op_t  a_op;
    logic [WW-1:0]        a_a;
    logic [WW-1:0]        a_b;
    logic                 a_done;
    logic [WW-1:0]        a_res;

    logic [31:0]          xj;
    logic signed [15:0]   vj;
    logic signed [31:0]   sqp;
    logic                 inwin;
    logic [SW-1:0]        sabs;
    logic [31:0]          n32;

    pwms_arith #(
        .WW(WW)
    ) u_arith (
        .clk   (clk),
        .rst_n (rst_n),
        .start (a_start),
        .op    (a_op),
        .a     (a_a),
        .b     (a_b),
        .done  (a_done),
        .result(a_res)
    );

    always_comb
    begin
        xj    = rdata[47:16];
        vj    = rdata[15:0];
        sqp   = vj * vj;
        inwin = ({1'b0, xj} + {1'b0, half_width} >= {1'b0, xc_reg}) &&
                ({1'b0, xj} <= {1'b0, xc_reg} + {1'b0, half_width});
        sabs  = s_reg[SW-1] ? SW'(-s_reg) : SW'(s_reg);
        n32   = 32'(n_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        xc_next    = xc_reg;
        ti_next    = ti_reg;
        iss_next   = 1'b0;
        p2_next    = 1'b0;
        in_next    = in_reg;
        val_next   = val_reg;
        sq_next    = sq_reg;
        s_next     = s_reg;
        q_next     = q_reg;
        n_next     = n_reg;
        mean_next  = mean_reg;
        sd_next    = sd_reg;
        t1_next    = t1_reg;
        t2_next    = t2_reg;
        den_next   = den_reg;
        raddr      = slot(oldest, center);
        a_start    = 1'b0;
        a_op       = pwms_pkg::OP_DIV;
        a_a        = WW'(sabs);
        a_b        = WW'(n_reg);
        unique case (state_reg)
            E_IDLE:
            begin
                if (start)
                begin
                    state_next = E_CRD;
                end
            end
            E_CRD:
            begin
                state_next = E_CAP;
            end
            E_CAP:
            begin
                xc_next    = xj;
                ti_next    = '0;
                s_next     = '0;
                q_next     = '0;
                n_next     = '0;
                state_next = E_SCAN;
            end
            E_SCAN:
            begin
                if (ti_reg < count)
                begin
                    raddr    = slot(oldest, ti_reg);
                    ti_next  = ti_reg + CW'(1);
                    iss_next = 1'b1;
                end
                if (iss_reg)
                begin
                    in_next  = inwin;
                    val_next = vj;
                    sq_next  = sqp[30:0];
                    p2_next  = 1'b1;
                end
                if (p2_reg && in_reg)
                begin
                    s_next = s_reg + SW'(val_reg);
                    q_next = q_reg + QW'(sq_reg);
                    n_next = n_reg + CW'(1);
                end
                if (ti_reg == count && !iss_reg && !p2_reg)
                begin
                    state_next = E_MEAN;
                end
            end
            E_MEAN:
            begin
                a_start    = 1'b1;
                state_next = E_MEANW;
            end
            E_MEANW:
            begin
                if (a_done)
                begin
                    mean_next = s_reg[SW-1] ? 16'(-a_res) : a_res[15:0];
                    if (n_reg < CW'(2))
                    begin
                        sd_next    = '0;
                        state_next = E_DONE;
                    end
                    else
                    begin
                        state_next = E_PROD;
                    end
                end
            end
            E_PROD:
            begin
                t1_next    = n_reg * q_reg;
                t2_next    = sabs * sabs;
                den_next   = n_reg * (n_reg - CW'(1));
                state_next = E_NUM;
            end
            E_NUM:
            begin
                a_start    = 1'b1;
                a_a        = WW'(t1_reg) - WW'(t2_reg);
                a_b        = WW'(den_reg);
                state_next = E_SDW;
            end
            E_SDW:
            begin
                if (a_done)
                begin
                    a_start    = 1'b1;
                    a_op       = pwms_pkg::OP_SQRT;
                    a_a        = a_res;
                    state_next = E_SQW;
                end
            end
            E_SQW:
            begin
                if (a_done)
                begin
                    sd_next    = (a_res > WW'(16'hFFFF)) ? 16'hFFFF : a_res[15:0];
                    state_next = E_DONE;
                end
            end
            E_DONE:
            begin
                state_next = E_IDLE;
            end
            default:
            begin
                state_next = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= E_IDLE;
            iss_reg   <= 1'b0;
            p2_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            iss_reg   <= iss_next;
            p2_reg    <= p2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        xc_reg   <= xc_next;
        ti_reg   <= ti_next;
        in_reg   <= in_next;
        val_reg  <= val_next;
        sq_reg   <= sq_next;
        s_reg    <= s_next;
        q_reg    <= q_next;
        n_reg    <= n_next;
        mean_reg <= mean_next;
        sd_reg   <= sd_next;
        t1_reg   <= t1_next;
        t2_reg   <= t2_next;
        den_reg  <= den_next;
    end

    assign busy      = (state_reg != E_IDLE);
    assign done      = (state_reg == E_DONE);
    assign res.pos   = xc_reg;
    assign res.mean  = mean_reg;
    assign res.sd    = sd_reg;
    assign res.count = (n32 > 32'd63) ? 6'd63 : n32[5:0];

endmodule

`default_nettype wire

// ===== design/position_window_mean_sd.sv =====
// ----------------------------------------------------------------------------
// position_window_mean_sd
// sliding window mean and sample standard deviation over positioned points
// ----------------------------------------------------------------------------
// s_axis carries one point per transaction (position, value, tlast = end of
// series); the user must write half_width through cfg_we / cfg_wdata only
// while idle, which the block itself does not enforce. m_axis carries one
// result per transaction; tlast marks the last result caused by an input
// point, tuser flags results given after ring overflow. s_axis_tready is
// high only while the sequencer is idle. The time each released result
// takes is set by the ring scan over one ram read port and the bit-serial
// divide / root unit shared by all results.
// The final result of a point is held back one stage so its tlast is known;
// when m_axis_tready is low, the block waits with a full output register.
// Reset empties the ring, clears the overflow flag and sets half_width to 0.
// ----------------------------------------------------------------------------
`default_nettype none

module position_window_mean_sd #(
    parameter int BUFFER_DEPTH = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,   // position[31:0], sample_value[47:32]
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [71:0] m_axis_tdata,   // center_position, window_mean, window_sd,
                                             // window_count, zero pad
    output logic             m_axis_tuser,   // truncated
    output logic             m_axis_tlast
);

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int CW = $clog2(BUFFER_DEPTH + 1);

    typedef enum logic [13:0] {
        S_IDLE     = 14'b00000000000001,
        S_REL_RD   = 14'b00000000000010,
        S_REL_CHK  = 14'b00000000000100,
        S_DROP_RD1 = 14'b00000000001000,
        S_DROP_LIM = 14'b00000000010000,
        S_DROP_RD2 = 14'b00000000100000,
        S_DROP_CHK = 14'b00000001000000,
        S_FULL     = 14'b00000010000000,
        S_FULL_FIN = 14'b00000100000000,
        S_WRITE    = 14'b00001000000000,
        S_EOS      = 14'b00010000000000,
        S_GIVE     = 14'b00100000000000,
        S_HOLD     = 14'b01000000000000,
        S_FIN      = 14'b10000000000000
    } st_t;

    function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
                                           input logic [CW-1:0] off);
        logic [CW:0] s;
        s = (CW+1)'(base) + (CW+1)'(off);
        if (s >= (CW+1)'(BUFFER_DEPTH))
        begin
            s = s - (CW+1)'(BUFFER_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] incr(input logic [AW-1:0] i);
        return (i == AW'(BUFFER_DEPTH - 1)) ? '0 : i + AW'(1);
    endfunction

    st_t state_reg, state_next;
    st_t ret_reg, ret_next;

    logic [31:0]    hw_reg;
    logic [31:0]    p_reg, p_next;
    logic [15:0]    v_reg, v_next;
    logic           eos_reg, eos_next;
    logic [31:0]    lim_reg, lim_next;
    logic [AW-1:0]  oldest_reg, oldest_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [CW-1:0]  pend_reg, pend_next;
    logic           ovf_reg, ovf_next;
    logic           inc_reg, inc_next;
    logic           start_reg, start_next;
    logic [CW-1:0]  center_reg, center_next;

    pwms_pkg::res_t held_res_reg, held_res_next;
    logic           held_tr_reg, held_tr_next;
    logic           held_v_reg, held_v_next;
    pwms_pkg::res_t out_res_reg, out_res_next;
    logic           out_tr_reg, out_tr_next;
    logic           out_last_reg, out_last_next;
    logic           out_v_reg, out_v_next;

    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    logic [AW-1:0]  top_raddr;
    logic [AW-1:0]  eng_raddr;
    logic [AW-1:0]  ram_raddr;
    logic [47:0]    ram_rdata;
    logic [31:0]    rd_pos;

    logic           eng_busy;
    logic           eng_done;
    pwms_pkg::res_t eng_res;

    logic           can_load;

    pwms_ram #(
        .WIDTH(48),
        .DEPTH(BUFFER_DEPTH)
    ) u_ring (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata({p_reg, v_reg}),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    pwms_stats #(
        .DEPTH(BUFFER_DEPTH)
    ) u_stats (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start_reg),
        .center    (center_reg),
        .oldest    (oldest_reg),
        .count     (cnt_reg),
        .half_width(hw_reg),
        .raddr     (eng_raddr),
        .rdata     (ram_rdata),
        .busy      (eng_busy),
        .done      (eng_done),
        .res       (eng_res)
    );

    assign rd_pos    = ram_rdata[47:16];
    assign ram_raddr = eng_busy ? eng_raddr : top_raddr;
    assign can_load  = !out_v_reg || m_axis_tready;

    always_comb
    begin
        state_next    = state_reg;
        ret_next      = ret_reg;
        p_next        = p_reg;
        v_next        = v_reg;
        eos_next      = eos_reg;
        lim_next      = lim_reg;
        oldest_next   = oldest_reg;
        cnt_next      = cnt_reg;
        pend_next     = pend_reg;
        ovf_next      = ovf_reg;
        inc_next      = inc_reg;
        start_next    = 1'b0;
        center_next   = center_reg;
        held_res_next = held_res_reg;
        held_tr_next  = held_tr_reg;
        held_v_next   = held_v_reg;
        out_res_next  = out_res_reg;
        out_tr_next   = out_tr_reg;
        out_last_next = out_last_reg;
        out_v_next    = out_v_reg && !m_axis_tready;
        ram_we        = 1'b0;
        ram_waddr     = slot(oldest_reg, cnt_reg);
        top_raddr     = slot(oldest_reg, pend_reg);
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    p_next     = s_axis_tdata[31:0];
                    v_next     = s_axis_tdata[47:32];
                    eos_next   = s_axis_tlast;
                    state_next = S_REL_RD;
                end
            end
            S_REL_RD:
            begin
                state_next = (pend_reg < cnt_reg) ? S_REL_CHK : S_DROP_RD1;
            end
            S_REL_CHK:
            begin
                if ({1'b0, rd_pos} + {1'b0, hw_reg} < {1'b0, p_reg})
                begin
                    start_next  = 1'b1;
                    center_next = pend_reg;
                    inc_next    = 1'b1;
                    ret_next    = S_REL_RD;
                    state_next  = S_GIVE;
                end
                else
                begin
                    state_next = S_DROP_RD1;
                end
            end
            S_DROP_RD1:
            begin
                if (pend_reg == '0)
                begin
                    state_next = S_FULL;
                end
                else if (pend_reg < cnt_reg)
                begin
                    state_next = S_DROP_LIM;
                end
                else
                begin
                    lim_next   = p_reg;
                    state_next = S_DROP_RD2;
                end
            end
            S_DROP_LIM:
            begin
                lim_next   = rd_pos;
                state_next = S_DROP_RD2;
            end
            S_DROP_RD2:
            begin
                top_raddr  = oldest_reg;
                state_next = (pend_reg == '0) ? S_FULL : S_DROP_CHK;
            end
            S_DROP_CHK:
            begin
                if ({1'b0, rd_pos} + {1'b0, hw_reg} < {1'b0, lim_reg})
                begin
                    oldest_next = incr(oldest_reg);
                    cnt_next    = cnt_reg - CW'(1);
                    pend_next   = pend_reg - CW'(1);
                    state_next  = S_DROP_RD2;
                end
                else
                begin
                    state_next = S_FULL;
                end
            end
            S_FULL:
            begin
                if (cnt_reg == CW'(BUFFER_DEPTH))
                begin
                    ovf_next = 1'b1;
                    if (pend_reg == '0)
                    begin
                        start_next  = 1'b1;
                        center_next = '0;
                        inc_next    = 1'b0;
                        ret_next    = S_FULL_FIN;
                        state_next  = S_GIVE;
                    end
                    else
                    begin
                        pend_next  = pend_reg - CW'(1);
                        state_next = S_FULL_FIN;
                    end
                end
                else
                begin
                    state_next = S_WRITE;
                end
            end
            S_FULL_FIN:
            begin
                oldest_next = incr(oldest_reg);
                cnt_next    = cnt_reg - CW'(1);
                state_next  = S_WRITE;
            end
            S_WRITE:
            begin
                ram_we     = 1'b1;
                cnt_next   = cnt_reg + CW'(1);
                state_next = eos_reg ? S_EOS : S_FIN;
            end
            S_EOS:
            begin
                if (pend_reg < cnt_reg)
                begin
                    start_next  = 1'b1;
                    center_next = pend_reg;
                    inc_next    = 1'b1;
                    ret_next    = S_EOS;
                    state_next  = S_GIVE;
                end
                else
                begin
                    oldest_next = '0;
                    cnt_next    = '0;
                    pend_next   = '0;
                    ovf_next    = 1'b0;
                    state_next  = S_FIN;
                end
            end
            S_GIVE:
            begin
                if (eng_done)
                begin
                    state_next = S_HOLD;
                end
            end
            S_HOLD:
            begin
                if (!held_v_reg || can_load)
                begin
                    if (held_v_reg)
                    begin
                        out_res_next  = held_res_reg;
                        out_tr_next   = held_tr_reg;
                        out_last_next = 1'b0;
                        out_v_next    = 1'b1;
                    end
                    held_res_next = eng_res;
                    held_tr_next  = ovf_reg;
                    held_v_next   = 1'b1;
                    pend_next     = pend_reg + CW'(inc_reg);
                    state_next    = ret_reg;
                end
            end
            S_FIN:
            begin
                if (!held_v_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (can_load)
                begin
                    out_res_next  = held_res_reg;
                    out_tr_next   = held_tr_reg;
                    out_last_next = 1'b1;
                    out_v_next    = 1'b1;
                    held_v_next   = 1'b0;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ret_reg    <= S_IDLE;
            hw_reg     <= '0;
            oldest_reg <= '0;
            cnt_reg    <= '0;
            pend_reg   <= '0;
            ovf_reg    <= 1'b0;
            inc_reg    <= 1'b0;
            start_reg  <= 1'b0;
            held_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ret_reg    <= ret_next;
            if (cfg_we)
            begin
                hw_reg <= cfg_wdata;
            end
            oldest_reg <= oldest_next;
            cnt_reg    <= cnt_next;
            pend_reg   <= pend_next;
            ovf_reg    <= ovf_next;
            inc_reg    <= inc_next;
            start_reg  <= start_next;
            held_v_reg <= held_v_next;
            out_v_reg  <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg        <= p_next;
        v_reg        <= v_next;
        eos_reg      <= eos_next;
        lim_reg      <= lim_next;
        center_reg   <= center_next;
        held_res_reg <= held_res_next;
        held_tr_reg  <= held_tr_next;
        out_res_reg  <= out_res_next;
        out_tr_reg   <= out_tr_next;
        out_last_reg <= out_last_next;
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = {2'b00, out_res_reg};
    assign m_axis_tuser  = out_tr_reg;
    assign m_axis_tlast  = out_last_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(BUFFER_DEPTH))
        else $error("ring fill count beyond depth");

    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= cnt_reg)
        else $error("pending index beyond fill count");

    a_idle_no_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !held_v_reg)
        else $error("held result left over in idle");

    a_engine_start: assert property (@(posedge clk) disable iff (!rst_n)
        start_reg |-> !eng_busy)
        else $error("result engine started while busy");

endmodule

`default_nettype wire
